// ----- hw/rtl/spint_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the servo pose interpolator.
// Used by spint_div, spint_ctrl, spint_dp and servo_pose_interpolator_unit.
package spint_pkg;

    localparam int NUM_JOINTS = 3;
    localparam int NUM_LANES  = NUM_JOINTS + 1;
    localparam int DLY_LANE   = NUM_JOINTS;
    localparam int ANGLE_W    = 8;
    localparam int STEP_W     = 8;
    localparam int DELAY_W    = 6;
    localparam int DVD_W      = ANGLE_W + STEP_W;
    localparam int DVS_W      = 8;
    localparam int CNT_W      = $clog2(DVD_W);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam int DELAY_SLOW = 35;
    localparam int DELAY_FAST = 6;
    localparam int DELAY_SPAN = DELAY_SLOW - DELAY_FAST;

    localparam logic [ANGLE_W-1:0] NEUTRAL_ANGLE   = 8'd90;
    localparam logic [ANGLE_W-1:0] ANGLE_MIN_RESET = 8'd0;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX_RESET = 8'd180;
    localparam logic [ANGLE_W-1:0] SPEED_MIN_RESET = 8'd1;
    localparam logic [ANGLE_W-1:0] SPEED_MAX_RESET = 8'd100;

    localparam logic [CFG_IDX_W-1:0] CFG_SHOULDER_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOULDER_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ELBOW_MIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ELBOW_MAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRIST_MIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WRIST_MAX    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MIN    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MAX    = 3'd7;

    typedef enum logic [1:0] {
        MS_STEP    = 2'd0,
        MS_DONE    = 2'd1,
        MS_ABORT   = 2'd2,
        MS_REFUSED = 2'd3
    } t_motion;

    typedef enum logic [1:0] {
        K_NONE    = 2'd0,
        K_EMIT    = 2'd1,
        K_COMPUTE = 2'd2
    } t_kind;

    typedef struct packed {
        logic               action;
        logic [ANGLE_W-1:0] target_shoulder;
        logic [ANGLE_W-1:0] target_elbow;
        logic [ANGLE_W-1:0] target_wrist;
        logic [ANGLE_W-1:0] speed;
        logic               emergency_stop;
    } t_in;

    typedef struct packed {
        logic [ANGLE_W-1:0] shoulder_angle;
        logic [ANGLE_W-1:0] elbow_angle;
        logic [ANGLE_W-1:0] wrist_angle;
        logic [1:0]         motion_status;
    } t_out;

    typedef struct packed {
        logic accept;
        logic load;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
    } t_stat;

endpackage

// ----- hw/rtl/spint_div.sv -----
`timescale 1ns / 1ps
// Restoring divider lane, one quotient bit per cycle while i_step is high.
// Depends on spint_pkg.
module spint_div import spint_pkg::*; (
    input  logic               i_clk,
    input  logic               i_start,
    input  logic               i_step,
    input  logic [DVD_W-1:0]   i_dvd,
    input  logic [DVS_W-1:0]   i_dvs,
    output logic [ANGLE_W-1:0] o_quo
);

    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_q;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   w_trial;
    logic             w_fit;

    assign w_trial = {r_rem, r_q[DVD_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dvd;
            r_dvs <= i_dvs;
        end else if (i_step) begin
            r_rem <= w_fit ? DVS_W'(w_trial - {1'b0, r_dvs}) : w_trial[DVS_W-1:0];
            r_q   <= {r_q[DVD_W-2:0], w_fit};
        end
    end

    assign o_quo = r_q[ANGLE_W-1:0];

endmodule

// ----- hw/rtl/spint_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencing state machine: accept, divider load, divide iterations, result.
// Depends on spint_pkg.
module spint_ctrl import spint_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cmd_valid,
    output logic  o_cmd_stall,
    output logic  o_pose_valid,
    input  logic  i_pose_stall,
    input  t_stat i_stat,
    output t_cmd  o_ctl
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             w_out_free;

    assign w_out_free = !r_out_valid || !i_pose_stall;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_ctl        = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_ctl.accept = 1'b1;
                    case (i_stat.kind)
                        K_COMPUTE: n_state = ST_LOAD;
                        K_EMIT:    n_state = ST_FIN;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD: begin
                o_ctl.load = 1'b1;
                n_cnt      = '0;
                n_state    = ST_DIV;
            end
            ST_DIV: begin
                o_ctl.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    o_ctl.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_pose_stall;
        if (o_ctl.finish) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd_stall  = (r_state != ST_IDLE);
    assign o_pose_valid = r_out_valid;

endmodule

// ----- hw/rtl/spint_dp.sv -----
`timescale 1ns / 1ps
// Datapath: limits, move state, clamping, products, divider lanes, result register.
// Depends on spint_pkg and spint_div.
module spint_dp import spint_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in                   i_cmd,
    input  t_cmd                  i_ctl,
    output t_stat                 o_stat,
    output t_out                  o_pose
);

    logic [ANGLE_W-1:0] r_jmin [NUM_JOINTS];
    logic [ANGLE_W-1:0] r_jmax [NUM_JOINTS];
    logic [ANGLE_W-1:0] r_spd_min, r_spd_max;

    logic [ANGLE_W-1:0] r_cur   [NUM_JOINTS];
    logic [ANGLE_W-1:0] r_start [NUM_JOINTS];
    logic [ANGLE_W-1:0] r_goal  [NUM_JOINTS];
    logic [STEP_W-1:0]  r_idx, r_total;
    logic [DELAY_W-1:0] r_dcount, r_dreload;
    logic               r_moving;
    logic               r_is_move, r_compute;
    t_motion            r_code;
    logic [ANGLE_W-1:0] r_speed;
    logic               r_neg [NUM_JOINTS];
    t_out               r_pose;

    logic [ANGLE_W-1:0] w_target [NUM_JOINTS];
    logic [ANGLE_W-1:0] w_goal   [NUM_JOINTS];
    logic [ANGLE_W-1:0] w_dist   [NUM_JOINTS];
    logic [ANGLE_W-1:0] w_max01, w_maxd;
    logic [STEP_W-1:0]  w_total;
    t_kind              w_kind;
    t_motion            w_code;

    logic               w_neg [NUM_JOINTS];
    logic [ANGLE_W-1:0] w_mag [NUM_JOINTS];
    logic [ANGLE_W-1:0] w_spd_x;
    logic [DVD_W-1:0]   w_dvd [NUM_LANES];
    logic [DVS_W-1:0]   w_dvs [NUM_LANES];
    logic [ANGLE_W-1:0] w_quo [NUM_LANES];
    logic [ANGLE_W-1:0] w_new [NUM_JOINTS];
    logic [DELAY_W-1:0] w_delay;

    assign w_target[0] = i_cmd.target_shoulder;
    assign w_target[1] = i_cmd.target_elbow;
    assign w_target[2] = i_cmd.target_wrist;

    // clamp and distance from the held pose
    always_comb begin
        for (int j = 0; j < NUM_JOINTS; j++) begin
            if (w_target[j] < r_jmin[j]) begin
                w_goal[j] = r_jmin[j];
            end else if (w_target[j] > r_jmax[j]) begin
                w_goal[j] = r_jmax[j];
            end else begin
                w_goal[j] = w_target[j];
            end
            w_dist[j] = (w_goal[j] >= r_cur[j]) ? w_goal[j] - r_cur[j]
                                                : r_cur[j] - w_goal[j];
        end
        w_max01 = (w_dist[0] > w_dist[1]) ? w_dist[0] : w_dist[1];
        w_maxd  = (w_max01 > w_dist[2]) ? w_max01 : w_dist[2];
        w_total = (w_maxd == '0) ? STEP_W'(1) : w_maxd;
    end

    always_comb begin
        w_kind = K_NONE;
        w_code = MS_STEP;
        if (!i_cmd.action) begin
            if (i_cmd.emergency_stop) begin
                w_kind = K_EMIT;
                w_code = MS_REFUSED;
            end else begin
                w_kind = K_COMPUTE;
            end
        end else if (!r_moving) begin
            w_kind = K_NONE;
        end else if (i_cmd.emergency_stop) begin
            w_kind = K_EMIT;
            w_code = MS_ABORT;
        end else if (r_dcount > DELAY_W'(1)) begin
            w_kind = K_NONE;
        end else if (r_idx >= r_total) begin
            w_kind = K_EMIT;
            w_code = MS_DONE;
        end else begin
            w_kind = K_COMPUTE;
        end
    end

    assign o_stat.kind = w_kind;

    // divider operands
    always_comb begin
        for (int j = 0; j < NUM_JOINTS; j++) begin
            w_neg[j] = (r_goal[j] < r_start[j]);
            w_mag[j] = w_neg[j] ? r_start[j] - r_goal[j] : r_goal[j] - r_start[j];
            w_dvd[j] = DVD_W'(w_mag[j]) * DVD_W'(r_idx);
            w_dvs[j] = r_total;
        end
        if (r_speed < r_spd_min) begin
            w_spd_x = r_spd_min;
        end else if (r_speed > r_spd_max) begin
            w_spd_x = r_spd_max;
        end else begin
            w_spd_x = r_speed;
        end
        if (r_spd_max > r_spd_min) begin
            w_dvd[DLY_LANE] = DVD_W'(DELAY_SPAN) * DVD_W'(w_spd_x - r_spd_min);
            w_dvs[DLY_LANE] = r_spd_max - r_spd_min;
        end else if (r_spd_max == r_spd_min) begin
            w_dvd[DLY_LANE] = '0;
            w_dvs[DLY_LANE] = DVS_W'(1);
        end else begin
            // reversed range: below min is slowest, anything else fastest
            w_dvd[DLY_LANE] = (r_speed < r_spd_min) ? '0 : DVD_W'(DELAY_SPAN);
            w_dvs[DLY_LANE] = DVS_W'(1);
        end
    end

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        spint_div u_div (
            .i_clk   (i_clk),
            .i_start (i_ctl.load),
            .i_step  (i_ctl.div_step),
            .i_dvd   (w_dvd[l]),
            .i_dvs   (w_dvs[l]),
            .o_quo   (w_quo[l])
        );
    end

    always_comb begin
        for (int j = 0; j < NUM_JOINTS; j++) begin
            w_new[j] = r_neg[j] ? r_start[j] - w_quo[j] : r_start[j] + w_quo[j];
        end
        w_delay = DELAY_W'(DELAY_SLOW) - w_quo[DLY_LANE][DELAY_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NUM_JOINTS; j++) begin
                r_jmin[j] <= ANGLE_MIN_RESET;
                r_jmax[j] <= ANGLE_MAX_RESET;
            end
            r_spd_min <= SPEED_MIN_RESET;
            r_spd_max <= SPEED_MAX_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SHOULDER_MIN: r_jmin[0] <= i_cfg_data;
                CFG_SHOULDER_MAX: r_jmax[0] <= i_cfg_data;
                CFG_ELBOW_MIN:    r_jmin[1] <= i_cfg_data;
                CFG_ELBOW_MAX:    r_jmax[1] <= i_cfg_data;
                CFG_WRIST_MIN:    r_jmin[2] <= i_cfg_data;
                CFG_WRIST_MAX:    r_jmax[2] <= i_cfg_data;
                CFG_SPEED_MIN:    r_spd_min <= i_cfg_data;
                CFG_SPEED_MAX:    r_spd_max <= i_cfg_data;
                default:          r_spd_max <= r_spd_max;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NUM_JOINTS; j++) begin
                r_cur[j]   <= NEUTRAL_ANGLE;
                r_start[j] <= NEUTRAL_ANGLE;
                r_goal[j]  <= NEUTRAL_ANGLE;
            end
            r_idx     <= '0;
            r_total   <= STEP_W'(1);
            r_dcount  <= '0;
            r_dreload <= '0;
            r_moving  <= 1'b0;
            r_is_move <= 1'b0;
            r_compute <= 1'b0;
            r_code    <= MS_STEP;
        end else begin
            if (i_ctl.accept) begin
                r_code    <= w_code;
                r_compute <= (w_kind == K_COMPUTE);
                r_is_move <= !i_cmd.action;
                if (!i_cmd.action) begin
                    if (!i_cmd.emergency_stop) begin
                        for (int j = 0; j < NUM_JOINTS; j++) begin
                            r_goal[j]  <= w_goal[j];
                            r_start[j] <= r_cur[j];
                        end
                        r_total  <= w_total;
                        r_idx    <= STEP_W'(1);
                        r_moving <= 1'b1;
                    end
                end else if (r_moving) begin
                    if (i_cmd.emergency_stop) begin
                        r_moving <= 1'b0;
                        r_dcount <= '0;
                    end else if (r_dcount > DELAY_W'(1)) begin
                        r_dcount <= r_dcount - 1'b1;
                    end else begin
                        r_dcount <= '0;
                        if (r_idx >= r_total) begin
                            r_moving <= 1'b0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
            end
            if (i_ctl.finish && r_compute) begin
                for (int j = 0; j < NUM_JOINTS; j++) begin
                    r_cur[j] <= w_new[j];
                end
                if (r_is_move) begin
                    r_dreload <= w_delay;
                    r_dcount  <= w_delay;
                end else begin
                    r_dcount <= r_dreload;
                end
            end
        end
    end

    // payload only
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_speed <= r_speed;
            for (int j = 0; j < NUM_JOINTS; j++) begin
                r_neg[j] <= w_neg[j];
            end
        end else if (i_ctl.accept) begin
            r_speed <= i_cmd.speed;
        end
        if (i_ctl.finish) begin
            r_pose.shoulder_angle <= r_compute ? w_new[0] : r_cur[0];
            r_pose.elbow_angle    <= r_compute ? w_new[1] : r_cur[1];
            r_pose.wrist_angle    <= r_compute ? w_new[2] : r_cur[2];
            r_pose.motion_status  <= r_code;
        end
    end

    assign o_pose = r_pose;

endmodule

// ----- hw/rtl/servo_pose_interpolator_unit.sv -----
`timescale 1ns / 1ps
// Three-joint servo pose interpolator, top level. Depends on spint_pkg, spint_ctrl, spint_dp.
// Move command or stepping tick: after acceptance, one operand load, the iterations of the
// four restoring divider lanes (one per dividend bit) and one result state; the next
// transaction is taken after the result. Refused, aborted and done results skip the load
// and division. Waiting and idle ticks: next transaction the following cycle.
// A stalled result holds the block in its result cycle until the output register frees.
// Reset (i_rst_n low, synchronous): idle, all joints 90, limits 0..180, speed 1..100.
module servo_pose_interpolator_unit import spint_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_stall,
    input  t_in                   i_cmd,
    output logic                  o_pose_valid,
    input  logic                  i_pose_stall,
    output t_out                  o_pose
);

    t_cmd  w_ctl;
    t_stat w_stat;

    spint_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (i_cmd_valid),
        .o_cmd_stall  (o_cmd_stall),
        .o_pose_valid (o_pose_valid),
        .i_pose_stall (i_pose_stall),
        .i_stat       (w_stat),
        .o_ctl        (w_ctl)
    );

    spint_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (i_cmd),
        .i_ctl      (w_ctl),
        .o_stat     (w_stat),
        .o_pose     (o_pose)
    );

    a_rise_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_pose_valid) |-> $past(w_ctl.finish))
        else $error("result appeared without a finish");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.finish |-> (!o_pose_valid || !i_pose_stall))
        else $error("pending result overwritten");

    a_busy_while_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.div_step || w_ctl.load) |-> o_cmd_stall)
        else $error("transaction taken while divider runs");

    a_accept_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.accept |-> !(w_ctl.load || w_ctl.div_step || w_ctl.finish))
        else $error("accept overlaps another command");

endmodule

// ----- tb/sv/servo_pose_interpolator_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for servo_pose_interpolator_unit: directed moves, ticks and stops,
// then random move/tick traffic over several limit settings, with both sides stalling.
// Depends on spint_pkg and the servo_pose_interpolator_unit RTL.
module servo_pose_interpolator_unit_test;
    import spint_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 24;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  i_cmd_valid  = 1'b0;
    logic                  o_cmd_stall;
    t_in                   i_cmd        = '0;
    logic                  o_pose_valid;
    logic                  i_pose_stall = 1'b0;
    t_out                  o_pose;

    // expected-behavior state
    logic [7:0] lim_lo[NUM_JOINTS]    = '{default: ANGLE_MIN_RESET};
    logic [7:0] lim_hi[NUM_JOINTS]    = '{default: ANGLE_MAX_RESET};
    logic [7:0] spd_lo                = SPEED_MIN_RESET;
    logic [7:0] spd_hi                = SPEED_MAX_RESET;
    logic [7:0] pose_now[NUM_JOINTS]  = '{default: NEUTRAL_ANGLE};
    logic [7:0] pose_from[NUM_JOINTS] = '{default: NEUTRAL_ANGLE};
    logic [7:0] pose_goal[NUM_JOINTS] = '{default: NEUTRAL_ANGLE};
    logic [7:0] step_idx              = 8'd0;
    logic [7:0] step_cnt              = 8'd1;
    logic [5:0] dly_left              = 6'd0;
    logic [5:0] dly_reload            = 6'd0;
    logic       in_motion             = 1'b0;

    t_out pending_poses[$];
    int   mismatch_count = 0;
    int   cycle_count    = 0;
    int   hold_cycles    = 0;
    bit   phase_idling   = 1'b1;
    bit   idle_on        = 1'b1;

    servo_pose_interpolator_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_cmd_valid  (i_cmd_valid),
        .o_cmd_stall  (o_cmd_stall),
        .i_cmd        (i_cmd),
        .o_pose_valid (o_pose_valid),
        .i_pose_stall (i_pose_stall),
        .o_pose       (o_pose)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int clamp_int(input int x, input int lo, input int hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    function automatic logic [5:0] step_delay(input logic [7:0] s);
        int lo, hi, x, q, d;
        lo = int'(spd_lo);
        hi = int'(spd_hi);
        x  = clamp_int(int'(s), lo, hi);
        q  = (hi == lo) ? 0 : ((x - lo) * (DELAY_FAST - DELAY_SLOW)) / (hi - lo);
        d  = q + DELAY_SLOW;
        return d[5:0];
    endfunction

    function automatic void interpolate_pose();
        int st, dl, idx, cnt, v;
        idx = int'(step_idx);
        cnt = int'(step_cnt);
        for (int j = 0; j < NUM_JOINTS; j++) begin
            st = int'(pose_from[j]);
            dl = int'(pose_goal[j]);
            dl = dl - st;
            v  = st + (dl * idx) / cnt;
            pose_now[j] = v[7:0];
        end
    endfunction

    function automatic t_out pose_result(input t_motion status);
        t_out r;
        r.shoulder_angle = pose_now[0];
        r.elbow_angle    = pose_now[1];
        r.wrist_angle    = pose_now[2];
        r.motion_status  = status;
        return r;
    endfunction

    // Updates the expected state for one accepted transaction and queues its pose, if any.
    function automatic void advance_motion(input t_in item);
        logic [7:0] target[NUM_JOINTS];
        int         goal, cur, span, widest;
        target[0] = item.target_shoulder;
        target[1] = item.target_elbow;
        target[2] = item.target_wrist;
        if (!item.action) begin
            if (item.emergency_stop) begin
                pending_poses.push_back(pose_result(MS_REFUSED));
            end else begin
                widest = 0;
                for (int j = 0; j < NUM_JOINTS; j++) begin
                    goal = clamp_int(int'(target[j]), int'(lim_lo[j]), int'(lim_hi[j]));
                    cur  = int'(pose_now[j]);
                    span = goal - cur;
                    if (span < 0) span = -span;
                    if (span > widest) widest = span;
                    pose_goal[j] = goal[7:0];
                    pose_from[j] = pose_now[j];
                end
                step_cnt   = (widest < 1) ? 8'd1 : widest[7:0];
                step_idx   = 8'd1;
                interpolate_pose();
                dly_reload = step_delay(item.speed);
                dly_left   = dly_reload;
                in_motion  = 1'b1;
                pending_poses.push_back(pose_result(MS_STEP));
            end
        end else if (in_motion) begin
            if (item.emergency_stop) begin
                in_motion = 1'b0;
                dly_left  = 6'd0;
                pending_poses.push_back(pose_result(MS_ABORT));
            end else if (dly_left > 6'd1) begin
                dly_left = dly_left - 6'd1;
            end else begin
                dly_left = 6'd0;
                if (step_idx >= step_cnt) begin
                    in_motion = 1'b0;
                    pending_poses.push_back(pose_result(MS_DONE));
                end else begin
                    step_idx = step_idx + 8'd1;
                    interpolate_pose();
                    dly_left = dly_reload;
                    pending_poses.push_back(pose_result(MS_STEP));
                end
            end
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    always @(posedge i_clk) begin : pose_check
        t_out want;
        if (i_rst_n && o_pose_valid && !i_pose_stall) begin
            if (pending_poses.size() == 0) begin
                report_mismatch($sformatf("unexpected pose %0d/%0d/%0d status %0d",
                    o_pose.shoulder_angle, o_pose.elbow_angle, o_pose.wrist_angle,
                    o_pose.motion_status));
            end else begin
                want = pending_poses.pop_front();
                check_field("shoulder_angle", int'(o_pose.shoulder_angle),
                            int'(want.shoulder_angle));
                check_field("elbow_angle", int'(o_pose.elbow_angle), int'(want.elbow_angle));
                check_field("wrist_angle", int'(o_pose.wrist_angle), int'(want.wrist_angle));
                check_field("motion_status", int'(o_pose.motion_status),
                            int'(want.motion_status));
            end
        end
    end

    initial begin : pose_stall_gen
        int burst;
        burst = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_pose_stall = 1'b1;
                hold_cycles--;
            end else if (burst > 0) begin
                i_pose_stall = 1'b1;
                burst--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 10) - 1;
                i_pose_stall = 1'b1;
            end else begin
                i_pose_stall = 1'b0;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic drive_command(input t_in item);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_cmd_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_cmd       = item;
        i_cmd_valid = 1'b1;
        do @(posedge i_clk); while (o_cmd_stall);
        advance_motion(item);
        @(negedge i_clk);
        i_cmd_valid = 1'b0;
    endtask

    function automatic t_in make_item(input logic action, input logic [7:0] sh,
                                      input logic [7:0] el, input logic [7:0] wr,
                                      input logic [7:0] speed, input logic estop);
        t_in r;
        r.action          = action;
        r.target_shoulder = sh;
        r.target_elbow    = el;
        r.target_wrist    = wr;
        r.speed           = speed;
        r.emergency_stop  = estop;
        return r;
    endfunction

    function automatic t_in random_item();
        return make_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endfunction

    function automatic logic [7:0] near_angle(input logic [7:0] a);
        int v;
        v = int'(a);
        v = v + int'($urandom_range(0, 8)) - 4;
        v = clamp_int(v, 0, 255);
        return v[7:0];
    endfunction

    task automatic wait_for_results();
        while (pending_poses.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_SHOULDER_MIN: lim_lo[0] = val;
            CFG_SHOULDER_MAX: lim_hi[0] = val;
            CFG_ELBOW_MIN:    lim_lo[1] = val;
            CFG_ELBOW_MAX:    lim_hi[1] = val;
            CFG_WRIST_MIN:    lim_lo[2] = val;
            CFG_WRIST_MAX:    lim_hi[2] = val;
            CFG_SPEED_MIN:    spd_lo    = val;
            CFG_SPEED_MAX:    spd_hi    = val;
            default: ;
        endcase
    endtask

    task automatic set_limits(input logic [7:0] sh_lo, input logic [7:0] sh_hi,
                              input logic [7:0] el_lo, input logic [7:0] el_hi,
                              input logic [7:0] wr_lo, input logic [7:0] wr_hi,
                              input logic [7:0] sp_lo, input logic [7:0] sp_hi);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        write_config(CFG_SHOULDER_MIN, sh_lo);
        write_config(CFG_SHOULDER_MAX, sh_hi);
        write_config(CFG_ELBOW_MIN, el_lo);
        write_config(CFG_ELBOW_MAX, el_hi);
        write_config(CFG_WRIST_MIN, wr_lo);
        write_config(CFG_WRIST_MAX, wr_hi);
        write_config(CFG_SPEED_MIN, sp_lo);
        write_config(CFG_SPEED_MAX, sp_hi);
    endtask

    // Mostly a move followed by its ticks; the rest refused moves and stray ticks.
    task automatic random_motion(input int budget);
        t_in it;
        int  counted, ticks, tick_cap, pick;
        counted = 0;
        while (counted < budget) begin
            idle_on = phase_idling && ($urandom_range(0, 4) != 0);
            pick    = $urandom_range(0, 99);
            if (pick < 70) begin
                it = random_item();
                it.action         = 1'b0;
                it.emergency_stop = 1'b0;
                if ($urandom_range(0, 3) != 0) begin
                    it.target_shoulder = near_angle(pose_now[0]);
                    it.target_elbow    = near_angle(pose_now[1]);
                    it.target_wrist    = near_angle(pose_now[2]);
                end
                if ($urandom_range(0, 9) < 6) it.speed = 8'hFF;
                drive_command(it);
                counted++;
                tick_cap = $urandom_range(1, 80);
                ticks    = 0;
                while (in_motion && ticks < tick_cap) begin
                    it = random_item();
                    it.action         = 1'b1;
                    it.emergency_stop = ($urandom_range(0, 49) == 0);
                    drive_command(it);
                    ticks++;
                    counted++;
                end
            end else if (pick < 82) begin
                it = random_item();
                it.action         = 1'b0;
                it.emergency_stop = 1'b1;
                drive_command(it);
                counted++;
            end else begin
                it = random_item();
                it.action = 1'b1;
                if (in_motion) counted++;
                drive_command(it);
            end
        end
    endtask

    task automatic test_idle_and_refused();
        drive_command(make_item(1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        drive_command(make_item(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
        drive_command(make_item(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
        drive_command(make_item(1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    endtask

    task automatic test_single_step_done();
        drive_command(make_item(1'b0, 8'd91, 8'd89, 8'd90, 8'hFF, 1'b0));
        while (in_motion) drive_command(make_item(1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        drive_command(make_item(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
    endtask

    task automatic test_replace_and_abort();
        drive_command(make_item(1'b0, 8'hFF, 8'd0, 8'd128, 8'd0, 1'b0));
        drive_command(make_item(1'b0, 8'd0, 8'hFF, 8'd0, 8'd100, 1'b1));
        drive_command(make_item(1'b0, 8'd0, 8'hFF, 8'd0, 8'd100, 1'b0));
        drive_command(make_item(1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        drive_command(make_item(1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        drive_command(make_item(1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    endtask

    task automatic test_stop_in_final_delay();
        drive_command(make_item(1'b0, pose_now[0], pose_now[1], pose_now[2], 8'hFF, 1'b0));
        while (dly_left > 6'd1) drive_command(make_item(1'b1, 8'd7, 8'd7, 8'd7, 8'd7, 1'b0));
        drive_command(make_item(1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
    endtask

    task automatic test_random_default();
        random_motion(250);
    endtask

    task automatic test_backpressure();
        t_in it;
        idle_on     = 1'b0;
        hold_cycles = 250;
        repeat (20) begin
            it = random_item();
            it.action = 1'b0;
            drive_command(it);
        end
        wait_for_results();
        idle_on = 1'b1;
        random_motion(250);
    endtask

    task automatic test_limit_extremes();
        set_limits(8'd180, 8'd180, 8'd0, 8'd0, 8'd40, 8'd140, 8'd0, 8'd255);
        random_motion(350);
    endtask

    task automatic test_reversed_ranges();
        set_limits(8'd150, 8'd30, 8'd180, 8'd0, 8'd100, 8'd99, 8'd200, 8'd50);
        random_motion(350);
    endtask

    task automatic test_flat_speed();
        set_limits(8'd0, 8'd180, 8'd0, 8'd180, 8'd0, 8'd180, 8'd77, 8'd77);
        random_motion(250);
    endtask

    task automatic test_no_idling();
        set_limits(8'd0, 8'd180, 8'd0, 8'd180, 8'd0, 8'd180, 8'd0, 8'd255);
        phase_idling = 1'b0;
        random_motion(350);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_idle_and_refused();
        test_single_step_done();
        test_replace_and_abort();
        test_stop_in_final_delay();
        test_random_default();
        test_backpressure();
        test_limit_extremes();
        test_reversed_ranges();
        test_flat_speed();
        test_no_idling();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
